// File: hdl/msp_pkg.sv
// Shared types, constants and channel-mapping helpers for the multiplexed
// servo pulse generator. No dependencies; used by the top level and its checker.
package msp_pkg;

  localparam int NUM_CHANNELS = 24;
  localparam int NUM_LANES    = 6;
  localparam int NUM_GROUPS   = 4;

  localparam int TICK_W  = 13;
  localparam int TRIM_W  = 8;
  localparam int KIND_W  = 2;
  localparam int CHAN_W  = 5;
  localparam int GROUP_W = 2;
  localparam int LANE_W  = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
  localparam int GRP_W   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int DIFF_W  = TICK_W + 2;

  localparam logic [TICK_W-1:0] SLOT_RESET = TICK_W'(5000 - 1);
  localparam logic [TICK_W-1:0] WIDTH_MAX  = TICK_W'(4500);

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK,
    KIND_WIDTH,
    KIND_TRIM
  } kind_t;

  typedef logic [NUM_CHANNELS-1:0] levels_t;

  // Group that a channel belongs to.
  function automatic logic [GRP_W-1:0] ch_grp(input logic [CHAN_W-1:0] ch);
    logic [GRP_W-1:0] g;
    g = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (ch == CHAN_W'(i)) g = GRP_W'(i / NUM_LANES);
    end
    return g;
  endfunction

  // Compare lane that a channel uses within its group.
  function automatic logic [LANE_W-1:0] ch_lane(input logic [CHAN_W-1:0] ch);
    logic [LANE_W-1:0] l;
    l = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (ch == CHAN_W'(i)) l = LANE_W'(i % NUM_LANES);
    end
    return l;
  endfunction

  // True when lane l of group g maps onto an existing channel.
  function automatic logic lane_ok(input logic [GRP_W-1:0] g, input int l);
    return (int'(g) * NUM_LANES + l) < NUM_CHANNELS;
  endfunction

  // Next group in the rotation.
  function automatic logic [GRP_W-1:0] grp_inc(input logic [GRP_W-1:0] g);
    return (g == GRP_W'(NUM_GROUPS - 1)) ? '0 : g + GRP_W'(1);
  endfunction

  // Pin bits owned by a group.
  function automatic levels_t grp_mask(input logic [GROUP_W-1:0] g);
    levels_t m;
    m = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (g == GROUP_W'(c / NUM_LANES)) m[c] = 1'b1;
    end
    return m;
  endfunction

endpackage

// File: hdl/multiplexed_servo_pwm_24ch.sv
// Top level of the 24-channel multiplexed servo pulse generator.
// Depends on msp_pkg for constants, the item kind enum and channel mapping.
//
// Usage: every item on the in_ channel is a transfer of one of three kinds:
// a one-microsecond tick, a pulse-width write or a trim write for one channel.
// Each accepted item yields exactly one result transfer on the out_ channel,
// carrying the 24 pin levels, the group driven in the current slot and a flag
// that marks the tick which started a new slot. Writes report the current
// levels without advancing time. The cfg_ channel sets slot_length (ticks per
// slot minus one) and is always ready; write it only while the block is idle.
// An item is registered in the input stage and its result is then loaded into
// the output register. Throughput is one item per cycle while out_ready stays
// high: the width and trim memories are read at each input transfer, for the
// group that follows the slot in progress, so a slot wrap finds the new group's
// row already registered.
// The output register and the input stage part the two sides, so a new item
// is taken while a finished result still waits. When the receiver stalls,
// the result holds and at most one more item is buffered before in_ready falls.
// Reset is synchronous and active low: it clears the tick counter, group,
// levels, lane compares and the per-entry valid bits of both tables (so all
// widths and trims read as zero), and restores slot_length to 4999.
module multiplexed_servo_pwm_24ch
  import msp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [KIND_W-1:0]       in_kind,
  input  logic [CHAN_W-1:0]       in_channel,
  input  logic [TICK_W-1:0]       in_pulse_width,
  input  logic signed [TRIM_W-1:0] in_trim,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [NUM_CHANNELS-1:0] out_pin_levels,
  output logic [GROUP_W-1:0]      out_active_group,
  output logic                    out_slot_start,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [TICK_W-1:0]       cfg_slot_length
);

  // Width and trim tables: one small memory per compare lane, addressed by group.
  logic [TICK_W-1:0] width_mem [NUM_LANES][NUM_GROUPS];
  logic [TRIM_W-1:0] trim_mem  [NUM_LANES][NUM_GROUPS];
  logic              wvld_r    [NUM_LANES][NUM_GROUPS];
  logic              tvld_r    [NUM_LANES][NUM_GROUPS];

  // Registered row of the group that follows the current one.
  logic [TICK_W-1:0] rd_width_r [NUM_LANES];
  logic [TRIM_W-1:0] rd_trim_r  [NUM_LANES];
  logic              rd_wvld_r  [NUM_LANES];
  logic              rd_tvld_r  [NUM_LANES];

  // Slot state.
  logic [TICK_W-1:0] slot_len_r;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [GRP_W-1:0]  grp_r, grp_nxt;
  logic [TICK_W-1:0] cmp_r [NUM_LANES];
  logic [TICK_W-1:0] cmp_nxt [NUM_LANES];
  levels_t           lvl_r, lvl_nxt;

  // Item stage and output register.
  logic              s1_vld_r;
  logic [KIND_W-1:0] s1_kind_r;
  logic              s1_fire;
  logic              in_fire;
  logic              wrap;
  logic              is_tick;
  logic [GRP_W-1:0]  rd_grp;

  logic              out_vld_r;
  levels_t           out_lvl_r;
  logic [GROUP_W-1:0] out_grp_r;
  logic              out_start_r;

  // Write decode.
  logic              wr_ok;
  logic [LANE_W-1:0] wr_lane;
  logic [GRP_W-1:0]  wr_grp;
  logic [TICK_W-1:0] wr_width;

  assign cfg_ready = 1'b1;

  assign s1_fire  = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  assign wr_ok    = in_channel < CHAN_W'(NUM_CHANNELS);
  assign wr_lane  = ch_lane(in_channel);
  assign wr_grp   = ch_grp(in_channel);
  assign wr_width = (in_pulse_width > WIDTH_MAX) ? WIDTH_MAX : in_pulse_width;

  assign is_tick = s1_kind_r == KIND_TICK;
  assign wrap    = is_tick && (tick_r >= slot_len_r);

  // The group after this cycle's item is done; the next item needs the row
  // of the group after that, in case it wraps.
  assign grp_nxt = (s1_fire && wrap) ? grp_inc(grp_r) : grp_r;
  assign rd_grp  = grp_inc(grp_nxt);

  // Tick processing: on a wrap, latch the prefetched row into the lanes and
  // raise the new group's pins; then drop any pin whose compare matches.
  always_comb begin
    logic signed [DIFF_W-1:0] diff;
    logic [TICK_W-1:0]        w;
    logic [TRIM_W-1:0]        t;
    levels_t                  base;
    logic [GRP_W-1:0]         g_use;
    logic [LANE_W-1:0]        ln;

    tick_nxt = wrap ? '0 : tick_r + TICK_W'(1);
    base     = lvl_r;
    if (wrap) base = '0;
    g_use    = wrap ? grp_inc(grp_r) : grp_r;

    for (int l = 0; l < NUM_LANES; l++) begin
      w    = rd_wvld_r[l] ? rd_width_r[l] : '0;
      t    = rd_tvld_r[l] ? rd_trim_r[l]  : '0;
      diff = $signed({2'b00, w}) - $signed({{(DIFF_W-TRIM_W){t[TRIM_W-1]}}, t});
      cmp_nxt[l] = cmp_r[l];
      if (wrap) begin
        if (!lane_ok(g_use, l) || diff[DIFF_W-1]) begin
          cmp_nxt[l] = '0;
        end else if (diff[DIFF_W-2:0] > {1'b0, slot_len_r}) begin
          cmp_nxt[l] = slot_len_r;
        end else begin
          cmp_nxt[l] = diff[TICK_W-1:0];
        end
      end
    end

    lvl_nxt = base;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      ln = ch_lane(CHAN_W'(c));
      if (ch_grp(CHAN_W'(c)) == g_use) begin
        if (wrap && rd_wvld_r[ln] && rd_width_r[ln] != '0) lvl_nxt[c] = 1'b1;
        if (cmp_nxt[ln] == tick_nxt) lvl_nxt[c] = 1'b0;
      end
    end
  end

  // Table memories: write at the input transfer, read the prefetch row.
  always_ff @(posedge clk) begin
    if (in_fire && wr_ok) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        if (wr_lane == LANE_W'(l)) begin
          if (in_kind == KIND_WIDTH) width_mem[l][wr_grp] <= wr_width;
          if (in_kind == KIND_TRIM)  trim_mem[l][wr_grp]  <= in_trim;
        end
      end
    end
    if (in_fire) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        rd_width_r[l] <= width_mem[l][rd_grp];
        rd_trim_r[l]  <= trim_mem[l][rd_grp];
        rd_wvld_r[l]  <= wvld_r[l][rd_grp];
        rd_tvld_r[l]  <= tvld_r[l][rd_grp];
      end
    end
  end

  // Entry valid bits stand in for clearing the tables at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
          wvld_r[l][g] <= 1'b0;
          tvld_r[l][g] <= 1'b0;
        end
      end
    end else if (in_fire && wr_ok) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        if (wr_lane == LANE_W'(l)) begin
          if (in_kind == KIND_WIDTH) wvld_r[l][wr_grp] <= 1'b1;
          if (in_kind == KIND_TRIM)  tvld_r[l][wr_grp] <= 1'b1;
        end
      end
    end
  end

  // Control and slot state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_len_r <= SLOT_RESET;
      tick_r     <= '0;
      grp_r      <= '0;
      lvl_r      <= '0;
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      for (int l = 0; l < NUM_LANES; l++) cmp_r[l] <= '0;
    end else begin
      if (cfg_valid) slot_len_r <= cfg_slot_length;
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (s1_fire && is_tick) begin
        tick_r <= tick_nxt;
        grp_r  <= grp_nxt;
        lvl_r  <= lvl_nxt;
        for (int l = 0; l < NUM_LANES; l++) cmp_r[l] <= cmp_nxt[l];
      end
    end
  end

  // Item stage payload and output register payload.
  always_ff @(posedge clk) begin
    if (in_fire) s1_kind_r <= in_kind;
    if (s1_fire) begin
      out_lvl_r   <= is_tick ? lvl_nxt : lvl_r;
      out_grp_r   <= GROUP_W'(grp_nxt);
      out_start_r <= wrap;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_pin_levels   = out_lvl_r;
  assign out_active_group = out_grp_r;
  assign out_slot_start   = out_start_r;

endmodule

// File: hdl/msp_checker.sv
// Port-level checker for the multiplexed servo pulse generator, bound to the top level.
// Depends on msp_pkg for widths and the group pin mask.
module msp_checker
  import msp_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [NUM_CHANNELS-1:0]  out_pin_levels,
  input logic [GROUP_W-1:0]       out_active_group,
  input logic                     out_slot_start,
  input logic                     cfg_valid,
  input logic                     cfg_ready
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pin_levels)
      && $stable(out_active_group) && $stable(out_slot_start))
    else $error("result changed while stalled");

  // Only the active group's pins may be high.
  a_group_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pin_levels & ~grp_mask(out_active_group)) == '0)
    else $error("pin high outside the active group");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // The configuration channel never back-pressures.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration transfer stalled");

endmodule

bind multiplexed_servo_pwm_24ch msp_checker u_msp_checker (.*);
